### sv/cmrs_pkg.sv
`timescale 1ns / 1ps
package cmrs_pkg;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;

  localparam logic [2:0] REG_RECT_LEFT   = 3'd0;
  localparam logic [2:0] REG_RECT_TOP    = 3'd1;
  localparam logic [2:0] REG_RECT_RIGHT  = 3'd2;
  localparam logic [2:0] REG_RECT_BOTTOM = 3'd3;
  localparam logic [2:0] REG_FILL_COLOUR = 3'd4;
  localparam logic [2:0] REG_CENTRE_X    = 3'd5;
  localparam logic [2:0] REG_CENTRE_Y    = 3'd6;
  localparam logic [2:0] REG_MASK_RADIUS = 3'd7;

  // control bits traveling with each request
  typedef struct packed {
    logic vld;
    logic inr;
  } tag_t;

endpackage

### sv/circle_masked_rect_span_unit.sv
`timescale 1ns / 1ps
// Channel  | Direction | Ports
// request  | in        | start, busy, scanline_i
// result   | out       | span_strobe_o, span_valid_o, span_start_o, span_end_o, span_colour_o
// config   | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A request is taken every cycle; busy stays low.
// The result strobes once its request has passed stages 1 to 3, the one-bit-per-stage
// root pipeline of COORD_BITS-1 stages, stage 4 and the output register.
// Reset clears the valid bits of all stages and the configuration registers.
// No stalls: results leave on the strobe cycle.
module circle_masked_rect_span_unit #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [COORD_BITS-1:0]              scanline_i,
  output logic                               span_strobe_o,
  output logic                               span_valid_o,
  output logic [COORD_BITS-1:0]              span_start_o,
  output logic [COORD_BITS-1:0]              span_end_o,
  output logic [31:0]                        span_colour_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cmrs_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [cmrs_pkg::DATA_BITS-1:0]     pwdata,
  output logic [cmrs_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready
);
  import cmrs_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int W   = COORD_BITS - 1;
  localparam int SW  = COORD_BITS + 2;
  localparam int LAT = W + 5;
  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  // configuration
  logic [C-1:0]  left_q, top_q, right_q, bottom_q, cx_q, cy_q;
  logic [W-1:0]  rad_q;
  logic [31:0]   colour_q;
  logic          wr_en;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
      colour_q <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      rad_q    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RECT_LEFT:   left_q   <= pwdata[C-1:0];
        REG_RECT_TOP:    top_q    <= pwdata[C-1:0];
        REG_RECT_RIGHT:  right_q  <= pwdata[C-1:0];
        REG_RECT_BOTTOM: bottom_q <= pwdata[C-1:0];
        REG_FILL_COLOUR: colour_q <= pwdata[31:0];
        REG_CENTRE_X:    cx_q     <= pwdata[C-1:0];
        REG_CENTRE_Y:    cy_q     <= pwdata[C-1:0];
        REG_MASK_RADIUS: rad_q    <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_RECT_LEFT:   prdata = DATA_BITS'(left_q);
      REG_RECT_TOP:    prdata = DATA_BITS'(top_q);
      REG_RECT_RIGHT:  prdata = DATA_BITS'(right_q);
      REG_RECT_BOTTOM: prdata = DATA_BITS'(bottom_q);
      REG_FILL_COLOUR: prdata = DATA_BITS'(colour_q);
      REG_CENTRE_X:    prdata = DATA_BITS'(cx_q);
      REG_CENTRE_Y:    prdata = DATA_BITS'(cy_q);
      REG_MASK_RADIUS: prdata = DATA_BITS'(rad_q);
      default:         prdata = '0;
    endcase
  end

  assign busy = 1'b0;

  // stage 1: row range check and |dy|
  logic signed [SW-1:0] y_s, cy_s, r_s, top_s, bot_s, cmr, cpr, ylo, yhi, dy, dya;
  tag_t                 s1_tag_d, s1_tag_q;
  logic [W-1:0]         s1_dy_q;

  always_comb begin
    y_s   = signed'({2'b00, scanline_i});
    cy_s  = signed'({2'b00, cy_q});
    r_s   = signed'({3'b000, rad_q});
    top_s = signed'({2'b00, top_q});
    bot_s = signed'({2'b00, bottom_q});
    cmr   = cy_s - r_s;
    cpr   = cy_s + r_s;
    ylo   = (cmr >= top_s) ? (cmr + ONE_S) : top_s;
    yhi   = (cpr <= bot_s) ? cpr : bot_s;
    dy    = y_s - cy_s;
    dya   = (dy < 0) ? -dy : dy;
    s1_tag_d.vld = start & ~busy;
    s1_tag_d.inr = (y_s >= ylo) && (y_s < yhi);
  end

  // stage 2: squares
  tag_t           s2_tag_q;
  logic [2*W-1:0] s2_rsq_q, s2_dsq_q;

  // stage 3: radicand
  tag_t           s3_tag_q;
  logic [2*W-1:0] s3_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
    end else begin
      s1_tag_q <= s1_tag_d;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dy_q  <= dya[W-1:0];
    s2_rsq_q <= {{W{1'b0}}, rad_q} * {{W{1'b0}}, rad_q};
    s2_dsq_q <= {{W{1'b0}}, s1_dy_q} * {{W{1'b0}}, s1_dy_q};
    s3_n_q   <= s2_rsq_q - s2_dsq_q;
  end

  // floor root
  tag_t         rt_tag;
  logic [W-1:0] rt_root;
  logic [W+1:0] rt_rem;

  cmrs_isqrt #(
    .ROOT_BITS (W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (s3_tag_q),
    .n_i    (s3_n_q),
    .tag_o  (rt_tag),
    .root_o (rt_root),
    .rem_o  (rt_rem)
  );

  // stage 4: round half up, n > s*s+s  <=>  rem > s
  tag_t       s4_tag_q;
  logic [W:0] s4_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_tag_q <= '0;
    end else begin
      s4_tag_q <= rt_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_h_q <= {1'b0, rt_root} + {{W{1'b0}}, (rt_rem > {2'b00, rt_root})};
  end

  // stage 5: span clip
  logic signed [SW-1:0] cx_s, h_s, left_s, right_s, lo, hi, strt, fin;
  logic                 span_ok;

  always_comb begin
    cx_s    = signed'({2'b00, cx_q});
    h_s     = signed'({{(SW-W-1){1'b0}}, s4_h_q});
    left_s  = signed'({2'b00, left_q});
    right_s = signed'({2'b00, right_q});
    lo      = cx_s - h_s;
    hi      = cx_s + h_s;
    strt    = (lo >= left_s) ? (lo + ONE_S) : left_s;
    fin     = (hi <= right_s) ? hi : right_s;
    span_ok = s4_tag_q.inr && (strt < fin);
  end

  logic         out_vld_q, out_ok_q;
  logic [C-1:0] out_start_q, out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_ok_q  <= 1'b0;
    end else begin
      out_vld_q <= s4_tag_q.vld;
      out_ok_q  <= span_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    out_start_q <= span_ok ? strt[C-1:0] : '0;
    out_end_q   <= span_ok ? fin[C-1:0] : '0;
  end

  assign span_strobe_o = out_vld_q;
  assign span_valid_o  = out_vld_q & out_ok_q;
  assign span_start_o  = out_start_q;
  assign span_end_o    = out_end_q;
  assign span_colour_o = colour_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT span_strobe_o)
    else $error("result strobe missing after request");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o |-> (span_start_o < span_end_o))
    else $error("valid span not increasing");

  a_span_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o |-> (span_end_o <= right_q) && (span_start_o > left_q || span_start_o == left_q))
    else $error("span outside rectangle");

endmodule

### sv/cmrs_isqrt.sv
`timescale 1ns / 1ps
module cmrs_isqrt #(
  parameter int ROOT_BITS = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmrs_pkg::tag_t             tag_i,
  input  logic [2*ROOT_BITS-1:0]     n_i,
  output cmrs_pkg::tag_t             tag_o,
  output logic [ROOT_BITS-1:0]       root_o,
  output logic [ROOT_BITS+1:0]       rem_o
);
  import cmrs_pkg::*;

  localparam int W  = ROOT_BITS;
  localparam int NW = 2 * ROOT_BITS;
  localparam int RW = ROOT_BITS + 2;

  tag_t            tag_q  [W];
  logic [NW-1:0]   n_q    [W];
  logic [RW-1:0]   rem_q  [W];
  logic [W-1:0]    q_q    [W];

  // one root bit per stage
  for (genvar k = 0; k < W; k++) begin : g_stage
    tag_t          tag_in;
    logic [NW-1:0] n_in;
    logic [RW-1:0] rem_in;
    logic [W-1:0]  q_in;
    logic [RW-1:0] rem_cat;
    logic [RW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign tag_in = tag_i;
      assign n_in   = n_i;
      assign rem_in = '0;
      assign q_in   = '0;
    end else begin : g_next
      assign tag_in = tag_q[k-1];
      assign n_in   = n_q[k-1];
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
    end

    assign rem_cat = {rem_in[W-1:0], n_in[NW-1:NW-2]};
    assign trial   = {q_in, 2'b01};
    assign ge      = (rem_cat >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else begin
        tag_q[k] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      n_q[k]   <= {n_in[NW-3:0], 2'b00};
      rem_q[k] <= ge ? (rem_cat - trial) : rem_cat;
      q_q[k]   <= {q_in[W-2:0], ge};
    end
  end

  assign tag_o  = tag_q[W-1];
  assign root_o = q_q[W-1];
  assign rem_o  = rem_q[W-1];

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_o.vld |-> (rem_o <= {1'b0, root_o, 1'b0}))
    else $error("root remainder above twice the root");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
class span_scoreboard #(int CW = 12);
  typedef struct {
    logic          valid;
    logic [CW-1:0] x0;
    logic [CW-1:0] x1;
    logic [31:0]   colour;
  } span_t;

  logic [CW-1:0] left;
  logic [CW-1:0] top;
  logic [CW-1:0] right;
  logic [CW-1:0] bottom;
  logic [CW-1:0] cx;
  logic [CW-1:0] cy;
  logic [CW-2:0] radius;
  logic [31:0]   colour;
  span_t         expected_spans[$];
  int            errors;

  function new();
    left   = '0;
    top    = '0;
    right  = '0;
    bottom = '0;
    cx     = '0;
    cy     = '0;
    radius = '0;
    colour = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      cmrs_pkg::REG_RECT_LEFT:   left   = value[CW-1:0];
      cmrs_pkg::REG_RECT_TOP:    top    = value[CW-1:0];
      cmrs_pkg::REG_RECT_RIGHT:  right  = value[CW-1:0];
      cmrs_pkg::REG_RECT_BOTTOM: bottom = value[CW-1:0];
      cmrs_pkg::REG_FILL_COLOUR: colour = value;
      cmrs_pkg::REG_CENTRE_X:    cx     = value[CW-1:0];
      cmrs_pkg::REG_CENTRE_Y:    cy     = value[CW-1:0];
      cmrs_pkg::REG_MASK_RADIUS: radius = value[CW-2:0];
      default: ;
    endcase
  endfunction

  function longint floor_sqrt(longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = longint'(1) << CW;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function span_t predict_span(logic [CW-1:0] row);
    span_t  sp;
    longint y, r, c_x, c_y, lft, tp, rgt, btm;
    longint ylo, yhi, dy, n, h, x0, x1;
    y   = row;
    r   = radius;
    c_x = cx;
    c_y = cy;
    lft = left;
    tp  = top;
    rgt = right;
    btm = bottom;
    sp.valid  = 1'b0;
    sp.x0     = '0;
    sp.x1     = '0;
    sp.colour = colour;
    ylo = (c_y - r >= tp) ? c_y - r + 1 : tp;
    yhi = (c_y + r <= btm) ? c_y + r : btm;
    if (y >= ylo && y < yhi) begin
      dy = y - c_y;
      n  = r * r - dy * dy;
      h  = floor_sqrt(n);
      // round half up
      if (n > h * h + h) h++;
      x0 = (c_x - h >= lft) ? c_x - h + 1 : lft;
      x1 = (c_x + h <= rgt) ? c_x + h : rgt;
      if (x0 < x1) begin
        sp.valid = 1'b1;
        sp.x0    = x0[CW-1:0];
        sp.x1    = x1[CW-1:0];
      end
    end
    return sp;
  endfunction

  function void note_request(logic [CW-1:0] row);
    expected_spans.push_back(predict_span(row));
  endfunction

  function int pending();
    return expected_spans.size();
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task check_result(logic v, logic [CW-1:0] x0, logic [CW-1:0] x1, logic [31:0] c);
    span_t sp;
    if (expected_spans.size() == 0) begin
      report_mismatch("result without request", 32'(v), 32'd0);
      return;
    end
    sp = expected_spans.pop_front();
    if (v !== sp.valid) report_mismatch("span_valid", 32'(v), 32'(sp.valid));
    if (x0 !== sp.x0) report_mismatch("span_start", 32'(x0), 32'(sp.x0));
    if (x1 !== sp.x1) report_mismatch("span_end", 32'(x1), 32'(sp.x1));
    if (c !== sp.colour) report_mismatch("span_colour", c, sp.colour);
  endtask
endclass

module testbench;
  localparam int CW   = 12;
  localparam int MAXC = (1 << CW) - 1;
  localparam int MAXR = (1 << (CW - 1)) - 1;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              start;
  logic                              busy;
  logic [CW-1:0]                     scanline_i;
  logic                              span_strobe_o;
  logic                              span_valid_o;
  logic [CW-1:0]                     span_start_o;
  logic [CW-1:0]                     span_end_o;
  logic [31:0]                       span_colour_o;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [cmrs_pkg::ADDR_BITS-1:0]    paddr;
  logic [cmrs_pkg::DATA_BITS-1:0]    pwdata;
  logic [cmrs_pkg::DATA_BITS-1:0]    prdata;
  logic                              pready;

  span_scoreboard #(CW) sb;

  circle_masked_rect_span_unit #(.COORD_BITS(CW)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .scanline_i    (scanline_i),
    .span_strobe_o (span_strobe_o),
    .span_valid_o  (span_valid_o),
    .span_start_o  (span_start_o),
    .span_end_o    (span_end_o),
    .span_colour_o (span_colour_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("circle_masked_rect_span_unit regression: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && span_strobe_o)
      sb.check_result(span_valid_o, span_start_o, span_end_o, span_colour_o);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
  endtask

  // upper bits above the register width carry junk
  function automatic logic [31:0] with_junk(input logic [31:0] field, input int bits);
    return (32'($urandom()) << bits) | field;
  endfunction

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic apply_config(input logic [CW-1:0] l, input logic [CW-1:0] t,
                              input logic [CW-1:0] rt, input logic [CW-1:0] b,
                              input logic [31:0] col, input logic [CW-1:0] x,
                              input logic [CW-1:0] y, input logic [CW-2:0] rad);
    drain();
    write_reg(cmrs_pkg::REG_RECT_LEFT,   with_junk(32'(l), CW));
    write_reg(cmrs_pkg::REG_RECT_TOP,    with_junk(32'(t), CW));
    write_reg(cmrs_pkg::REG_RECT_RIGHT,  with_junk(32'(rt), CW));
    write_reg(cmrs_pkg::REG_RECT_BOTTOM, with_junk(32'(b), CW));
    write_reg(cmrs_pkg::REG_FILL_COLOUR, col);
    write_reg(cmrs_pkg::REG_CENTRE_X,    with_junk(32'(x), CW));
    write_reg(cmrs_pkg::REG_CENTRE_Y,    with_junk(32'(y), CW));
    write_reg(cmrs_pkg::REG_MASK_RADIUS, with_junk(32'(rad), CW - 1));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_row(input logic [CW-1:0] row);
    start      <= 1'b1;
    scanline_i <= row;
    do @(posedge clk_i); while (busy);
    sb.note_request(row);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      start      <= 1'b0;
      scanline_i <= CW'($urandom_range(0, MAXC));
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap(input bit bursty);
    int k;
    k = $urandom_range(0, 99);
    if (bursty || k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // mostly rows inside or at the edge of the circle's vertical range
  function automatic logic [CW-1:0] pick_row();
    int     k;
    longint r, c;
    k = $urandom_range(0, 9);
    r = sb.radius;
    c = sb.cy;
    if (k < 6) return CW'(c - r + $urandom_range(0, 2 * r));
    if (k < 8) return CW'(($urandom_range(0, 1) ? c + r : c - r) + $urandom_range(0, 2) - 1);
    if (k < 9)
      return CW'(longint'($urandom_range(0, 1) ? sb.top : sb.bottom) + $urandom_range(0, 2) - 1);
    return CW'($urandom_range(0, MAXC));
  endfunction

  task automatic random_config();
    logic [CW-1:0] l, t, rt, b, x, y, tmp;
    logic [CW-2:0] rad;
    int            mode;
    mode = $urandom_range(0, 4);
    l    = CW'($urandom_range(0, MAXC));
    rt   = CW'($urandom_range(0, MAXC));
    t    = CW'($urandom_range(0, MAXC));
    b    = CW'($urandom_range(0, MAXC));
    x    = CW'($urandom_range(0, MAXC));
    y    = CW'($urandom_range(0, MAXC));
    rad  = (CW-1)'($urandom_range(0, MAXR));
    case (mode)
      1: begin
        l  = '0;
        t  = '0;
        rt = CW'(MAXC);
        b  = CW'(MAXC);
      end
      2: begin
        x   = $urandom_range(0, 1) ? CW'(MAXC) : '0;
        y   = $urandom_range(0, 1) ? CW'(MAXC) : '0;
        rad = (CW-1)'(MAXR);
      end
      3: begin
        l   = '0;
        t   = '0;
        rt  = CW'(MAXC);
        b   = CW'(MAXC);
        rad = (CW-1)'($urandom_range(1, 8));
      end
      4: begin
        if (l > rt) begin
          tmp = l;
          l   = rt;
          rt  = tmp;
        end
        if (t > b) begin
          tmp = t;
          t   = b;
          b   = tmp;
        end
        rad = (CW-1)'($urandom_range(100, MAXR));
      end
      default: ;
    endcase
    apply_config(l, t, rt, b, $urandom(), x, y, rad);
  endtask

  initial begin
    bit bursty;
    sb         = new();
    rst_ni     = 1'b0;
    start      = 1'b0;
    scanline_i = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: zero radius, nothing valid
    send_row(CW'(0));
    send_row(CW'(MAXC));
    send_row(CW'(12'hAAA));
    send_row(CW'(12'h555));

    // circle hanging past the left edge
    apply_config(12'd100, 12'd50, 12'd3000, 12'd4000, 32'hA5A5_5A5A, 12'd20, 12'd2000, 11'd500);
    send_row(12'd1500);
    send_row(12'd1501);
    send_row(12'd2000);
    send_row(12'd2499);
    send_row(12'd2500);
    send_row(12'd1800);

    // extremes
    apply_config('0, '0, CW'(MAXC), CW'(MAXC), 32'hFFFF_FFFF, CW'(MAXC), '0, (CW-1)'(MAXR));
    send_row(12'd0);
    send_row(12'd2046);
    send_row(12'd2047);
    send_row(CW'(MAXC));
    send_row(12'd1000);

    // empty rectangle
    apply_config(CW'(MAXC), '0, '0, CW'(MAXC), 32'h0000_0001, 12'd2048, 12'd2048, 11'd1);
    send_row(12'd2048);
    send_row(12'd2047);

    // unit radius at the corner
    apply_config('0, '0, CW'(MAXC), CW'(MAXC), 32'h8000_0000, '0, CW'(MAXC), 11'd1);
    send_row(CW'(MAXC));
    send_row(12'd4094);

    for (int p = 0; p < 10; p++) begin
      random_config();
      bursty = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < 70; i++) begin
        send_row(pick_row());
        if ($urandom_range(0, 49) == 0) drain();
        else idle(pick_gap(bursty));
      end
    end

    drain();
    repeat (CW + 8) @(posedge clk_i);
    if (sb.errors == 0)
      $display("circle_masked_rect_span_unit regression: pass");
    else
      $display("circle_masked_rect_span_unit regression: fail");
    $finish;
  end
endmodule

### files.f
sv/cmrs_pkg.sv
sv/cmrs_isqrt.sv
sv/circle_masked_rect_span_unit.sv
sim/testbench.sv
